/* rtl/core/tld_pkg.sv */
package tld_pkg;

    // Default line store depth; the store holds one entry less than this
    localparam int LINE_DEPTH_DEF = 16;

    // Request types
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_RAW_MODE   = 3'd0;
    localparam logic [2:0] REG_ECHO_ON    = 3'd1;
    localparam logic [2:0] REG_ERASE_CHAR = 3'd2;
    localparam logic [2:0] REG_KILL_CHAR  = 3'd3;
    localparam logic [2:0] REG_INTR_CHAR  = 3'd4;
    localparam logic [2:0] REG_EOF_CHAR   = 3'd5;
    localparam logic [2:0] REG_EOL_CHAR   = 3'd6;

    // Register reset values
    localparam logic [7:0] RST_ERASE = 8'h7F;
    localparam logic [7:0] RST_KILL  = 8'h15;
    localparam logic [7:0] RST_INTR  = 8'h03;
    localparam logic [7:0] RST_EOF   = 8'h04;
    localparam logic [7:0] RST_EOL   = 8'h0A;

    // Characters
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_FIN_LO = 8'h40;
    localparam logic [7:0] CH_FIN_HI = 8'h7E;

    typedef enum logic [1:0] {
        ESC_GROUND = 2'd0,
        ESC_ESC    = 2'd1,
        ESC_CSI    = 2'd2,
        ESC_OSC    = 2'd3
    } t_esc;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_READ = 3'd1,
        S_INTR = 3'd2,
        S_BS   = 3'd3,
        S_CHAR = 3'd4,
        S_EOL  = 3'd5,
        S_STAT = 3'd6
    } t_state;

    // Escape filter result toward the line handler
    typedef struct packed {
        logic        pass;
        logic [31:0] seq_count;
    } t_filt_res;

endpackage

/* rtl/core/tld_esc_filter.sv */
module tld_esc_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    output tld_pkg::t_filt_res o_res
);
    import tld_pkg::*;

    t_esc        r_esc, n_esc;
    logic [31:0] r_seq, n_seq;
    logic        w_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= ESC_GROUND;
            r_seq <= '0;
        end else if (i_step) begin
            r_esc <= n_esc;
            r_seq <= n_seq;
        end
    end

    always_comb begin
        n_esc  = r_esc;
        n_seq  = r_seq;
        w_pass = 1'b0;
        unique case (r_esc)
            ESC_GROUND: begin
                if (i_byte == CH_ESC) n_esc = ESC_ESC;
                else w_pass = 1'b1;
            end
            ESC_ESC: begin
                if (i_byte == CH_LBRACK) begin
                    n_esc = ESC_CSI;
                end else if (i_byte == CH_RBRACK) begin
                    n_esc = ESC_OSC;
                end else begin
                    n_esc  = ESC_GROUND;
                    w_pass = 1'b1;
                end
            end
            ESC_CSI: begin
                // parameter bytes keep the sequence open
                if (!((i_byte >= CH_DIG_LO && i_byte <= CH_DIG_HI) || i_byte == CH_SEMI)) begin
                    if (i_byte >= CH_FIN_LO && i_byte <= CH_FIN_HI) n_seq = r_seq + 32'd1;
                    n_esc = ESC_GROUND;
                end
            end
            ESC_OSC: begin
                if (i_byte == CH_BEL || i_byte == CH_ESC) n_esc = ESC_GROUND;
            end
            default: n_esc = ESC_GROUND;
        endcase
    end

    assign o_res.pass      = w_pass;
    assign o_res.seq_count = r_seq;

endmodule

/* rtl/core/terminal_line_discipline.sv */
// Channel   Direction  Handshake                Payload
// in        sink       i_in_valid / o_in_ready   i_req_type, i_rx_byte, i_max_len
// out       source     o_out_valid / i_out_ready o_kind, o_data, o_last, o_line_ready,
//                                                o_lines_count, o_escape_count
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_addr, i_cfg_data
//
// Each item gives R results (1 to 3*(LINE_DEPTH-1)); while the output is not stalled,
// the sequencer emits one result per cycle through the single output register.
// The input is not ready until the last result of the item is loaded; the next
// item may transfer while that result still waits in the output register.
// Output stalls freeze the sequencer. Reset is synchronous, active low, and needs
// no clearing pass; the config channel is always ready.
module terminal_line_discipline #(
    parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_max_len,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data,
    output logic        o_last,
    output logic        o_line_ready,
    output logic [31:0] o_lines_count,
    output logic [31:0] o_escape_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);
    import tld_pkg::*;

    localparam int LEN_W = $clog2(LINE_DEPTH);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_DEPTH - 1);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    // configuration
    logic       r_raw, r_echo;
    logic [7:0] r_erase, r_kill, r_intr, r_eof, r_eol;

    // line state
    logic [7:0]       r_store [LINE_DEPTH];
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ready, n_ready;
    logic [31:0]      r_lines, n_lines;

    // sequencer
    t_state           r_state, n_state;
    logic [2:0]       r_sub, n_sub;
    logic [LEN_W-1:0] r_cnt, n_cnt;   // BS triples left or line bytes left
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [7:0]       r_chr, n_chr;
    logic             r_eol_pend, n_eol_pend;
    logic [7:0]       r_stat, n_stat;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_data;
    logic        r_last, r_oready;
    logic [31:0] r_olines, r_oesc;

    t_filt_res        w_filt;
    logic             w_in_acc, w_slot, w_step, w_room, w_is_eol, w_wr, w_two;
    logic             w_load, w_last;
    logic [1:0]       w_kind;
    logic [7:0]       w_data, w_maxm1;
    logic [LEN_W-1:0] w_rd_n, w_dec;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_slot = !r_out_valid || i_out_ready;
    assign w_step = w_in_acc && (i_req_type == REQ_BYTE) && !r_raw;
    assign w_room = (r_len < LEN_MAX);
    assign w_is_eol = (i_rx_byte == r_eol) || (i_rx_byte == CH_CR);
    assign w_two = (r_chr == CH_LF);
    // shared countdown for rubout echo (erase and kill) and line read out
    assign w_dec = r_cnt - LEN_ONE;

    // read count: max_len of zero means no limit
    assign w_maxm1 = i_max_len - 8'd1;
    assign w_rd_n = (i_max_len != 8'd0 && {{(8 - LEN_W){1'b0}}, r_len} > w_maxm1)
                    ? w_maxm1[LEN_W-1:0] : r_len;

    tld_esc_filter u_filt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (i_rx_byte),
        .o_res   (w_filt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw   <= 1'b0;
            r_echo  <= 1'b1;
            r_erase <= RST_ERASE;
            r_kill  <= RST_KILL;
            r_intr  <= RST_INTR;
            r_eof   <= RST_EOF;
            r_eol   <= RST_EOL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_RAW_MODE:   r_raw   <= i_cfg_data[0];
                REG_ECHO_ON:    r_echo  <= i_cfg_data[0];
                REG_ERASE_CHAR: r_erase <= i_cfg_data;
                REG_KILL_CHAR:  r_kill  <= i_cfg_data;
                REG_INTR_CHAR:  r_intr  <= i_cfg_data;
                REG_EOF_CHAR:   r_eof   <= i_cfg_data;
                REG_EOL_CHAR:   r_eol   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // line store: written at the current length, read at the read-out index
    always_ff @(posedge i_clk) begin
        if (w_wr) r_store[r_len] <= i_rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sub      <= '0;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_len      <= '0;
            r_ready    <= 1'b0;
            r_lines    <= '0;
            r_eol_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sub      <= n_sub;
            r_cnt      <= n_cnt;
            r_idx      <= n_idx;
            r_len      <= n_len;
            r_ready    <= n_ready;
            r_lines    <= n_lines;
            r_eol_pend <= n_eol_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chr  <= n_chr;
        r_stat <= n_stat;
    end

    always_comb begin
        n_state    = r_state;
        n_sub      = r_sub;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_len      = r_len;
        n_ready    = r_ready;
        n_lines    = r_lines;
        n_chr      = r_chr;
        n_eol_pend = r_eol_pend;
        n_stat     = r_stat;
        w_wr       = 1'b0;
        w_load     = 1'b0;
        w_kind     = KIND_ECHO;
        w_data     = '0;
        w_last     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_stat  = '0;
                    n_sub   = '0;
                    n_state = S_STAT;
                    if (i_req_type == REQ_READ) begin
                        if (r_ready) begin
                            n_len   = '0;
                            n_ready = 1'b0;
                            n_cnt   = w_rd_n;
                            n_idx   = '0;
                            n_stat  = 8'(w_rd_n);
                            if (w_rd_n != '0) n_state = S_READ;
                        end
                    end else if (r_raw) begin
                        if (w_room) begin
                            w_wr  = 1'b1;
                            n_len = r_len + LEN_ONE;
                        end
                        n_ready = 1'b1;
                    end else if (w_filt.pass) begin
                        if (i_rx_byte == r_intr) begin
                            n_len = '0;
                            if (r_echo) n_state = S_INTR;
                        end else if (i_rx_byte == r_eof && r_len == '0) begin
                            n_ready = 1'b1;
                        end else if ((i_rx_byte == r_erase || i_rx_byte == CH_BS)
                                     && r_len != '0) begin
                            n_len = r_len - LEN_ONE;
                            if (r_echo) begin
                                n_cnt   = LEN_ONE;
                                n_state = S_BS;
                            end
                        end else if (i_rx_byte == r_kill) begin
                            n_len = '0;
                            if (r_echo && r_len != '0) begin
                                n_cnt   = r_len;
                                n_state = S_BS;
                            end
                        end else begin
                            // plain append; full store drops the byte but not the EOL
                            n_chr      = i_rx_byte;
                            n_eol_pend = r_echo && w_is_eol;
                            if (w_room) begin
                                w_wr  = 1'b1;
                                n_len = r_len + LEN_ONE;
                            end
                            if (w_is_eol) begin
                                n_ready = 1'b1;
                                n_lines = r_lines + 32'd1;
                            end
                            if (r_echo && w_room) n_state = S_CHAR;
                            else if (r_echo && w_is_eol) n_state = S_EOL;
                        end
                    end
                end
            end
            S_READ: begin
                if (w_slot) begin
                    w_load = 1'b1;
                    w_kind = KIND_LINE;
                    w_data = r_store[r_idx];
                    n_idx  = r_idx + LEN_ONE;
                    n_cnt  = w_dec;
                    if (r_cnt == LEN_ONE) n_state = S_STAT;
                end
            end
            S_INTR: begin
                // ^ C CR CR LF: the LF of the string is expanded too
                if (w_slot) begin
                    w_load = 1'b1;
                    case (r_sub)
                        3'd0:    w_data = CH_CARET;
                        3'd1:    w_data = CH_C;
                        3'd4:    w_data = CH_LF;
                        default: w_data = CH_CR;
                    endcase
                    w_last = (r_sub == 3'd4);
                    if (w_last) begin
                        n_sub   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            S_BS: begin
                if (w_slot) begin
                    w_load = 1'b1;
                    w_data = (r_sub == 3'd1) ? CH_SP : CH_BS;
                    if (r_sub == 3'd2) begin
                        n_sub = '0;
                        if (r_cnt == LEN_ONE) begin
                            w_last  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_cnt = w_dec;
                        end
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            S_CHAR: begin
                if (w_slot) begin
                    w_load = 1'b1;
                    w_data = (w_two && r_sub == 3'd0) ? CH_CR : r_chr;
                    if (!w_two || r_sub == 3'd1) begin
                        w_last  = !r_eol_pend;
                        n_sub   = '0;
                        n_state = r_eol_pend ? S_EOL : S_IDLE;
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            S_EOL: begin
                // CR then the expanded LF
                if (w_slot) begin
                    w_load = 1'b1;
                    w_data = (r_sub == 3'd2) ? CH_LF : CH_CR;
                    if (r_sub == 3'd2) begin
                        w_last  = 1'b1;
                        n_sub   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            S_STAT: begin
                if (w_slot) begin
                    w_load  = 1'b1;
                    w_kind  = KIND_STAT;
                    w_data  = r_stat;
                    w_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register; state fields are already final when results go out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind   <= w_kind;
            r_data   <= w_data;
            r_last   <= w_last;
            r_oready <= r_ready;
            r_olines <= r_lines;
            r_oesc   <= w_filt.seq_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_data         = r_data;
    assign o_last         = r_last;
    assign o_line_ready   = r_oready;
    assign o_lines_count  = r_olines;
    assign o_escape_count = r_oesc;

    // every item leaves at least one result to emit
    a_item_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state != S_IDLE)
        else $error("item accepted without pending result");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("line length beyond store");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> r_state == S_IDLE)
        else $error("final result loaded but sequencer not idle");

    a_read_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_BS) |-> r_cnt != '0)
        else $error("countdown empty while emitting");

    a_lines_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_lines))
        else $error("line counter moved without a transfer");

endmodule

/* verif/tld_line_checker.sv */
// Watches the three channels of terminal_line_discipline, predicts the output
// transfers of every accepted input transfer and compares them in order.
module tld_line_checker #(
    parameter int DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_max_len,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data,
    input  logic        i_last,
    input  logic        i_line_ready,
    input  logic [31:0] i_lines_count,
    input  logic [31:0] i_escape_count,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output logic [31:0] o_csi_total
);

    import tld_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic        line_rdy;
        logic [31:0] lines;
        logic [31:0] csis;
    } t_tty_res;

    // shadow registers
    logic       raw_en, echo_en;
    logic [7:0] erase_ch, kill_ch, intr_ch, eof_ch, eol_ch;

    // shadow line discipline state
    logic [7:0]  shadow_store [DEPTH];
    int          shadow_len;
    logic        rdy;
    t_esc        esc_st;
    logic [31:0] line_cnt, csi_cnt;

    logic [7:0] echo_bytes [$];
    t_tty_res   tty_out_q [$];
    t_tty_res   want, got;
    int         errs, checked;

    function automatic void push_res(input logic [1:0] k, input logic [7:0] d, input logic l);
        t_tty_res r;
        r = {k, d, l, rdy, line_cnt, csi_cnt};
        tty_out_q.push_back(r);
    endfunction

    // LF always leaves as CR LF, fixed strings included
    function automatic void echo_tty(input logic [7:0] b);
        if (b == CH_LF) echo_bytes.push_back(CH_CR);
        echo_bytes.push_back(b);
    endfunction

    function automatic void echo_rubout();
        echo_tty(CH_BS);
        echo_tty(CH_SP);
        echo_tty(CH_BS);
    endfunction

    // 1 when the byte leaves the escape filter toward line handling
    function automatic bit esc_pass(input logic [7:0] b);
        case (esc_st)
            ESC_GROUND: begin
                if (b == CH_ESC) begin
                    esc_st = ESC_ESC;
                    return 1'b0;
                end
                return 1'b1;
            end
            ESC_ESC: begin
                if (b == CH_LBRACK) begin
                    esc_st = ESC_CSI;
                    return 1'b0;
                end
                if (b == CH_RBRACK) begin
                    esc_st = ESC_OSC;
                    return 1'b0;
                end
                esc_st = ESC_GROUND;
                return 1'b1;
            end
            ESC_CSI: begin
                if ((b >= CH_DIG_LO && b <= CH_DIG_HI) || b == CH_SEMI) return 1'b0;
                if (b >= CH_FIN_LO && b <= CH_FIN_HI) csi_cnt++;
                esc_st = ESC_GROUND;
                return 1'b0;
            end
            default: begin
                if (b == CH_BEL || b == CH_ESC) esc_st = ESC_GROUND;
                return 1'b0;
            end
        endcase
    endfunction

    // full store drops the byte, no echo either
    function automatic void store_byte(input logic [7:0] b, input logic echo);
        if (shadow_len < DEPTH - 1) begin
            shadow_store[shadow_len] = b;
            shadow_len++;
            if (echo) echo_tty(b);
        end
    endfunction

    function automatic void cook_byte(input logic [7:0] b);
        if (!esc_pass(b)) return;
        if (b == intr_ch) begin
            shadow_len = 0;
            if (echo_en) begin
                echo_tty(CH_CARET);
                echo_tty(CH_C);
                echo_tty(CH_CR);
                echo_tty(CH_LF);
            end
            return;
        end
        if (b == eof_ch && shadow_len == 0) begin
            rdy = 1'b1;
            return;
        end
        if ((b == erase_ch || b == CH_BS) && shadow_len > 0) begin
            shadow_len--;
            if (echo_en) echo_rubout();
            return;
        end
        if (b == kill_ch) begin
            while (shadow_len > 0) begin
                shadow_len--;
                if (echo_en) echo_rubout();
            end
            return;
        end
        store_byte(b, echo_en);
        if (b == eol_ch || b == CH_CR) begin
            if (echo_en) begin
                echo_tty(CH_CR);
                echo_tty(CH_LF);
            end
            rdy = 1'b1;
            line_cnt++;
        end
    endfunction

    function automatic void compute_tty_response(input logic req, input logic [7:0] b,
                                                 input logic [7:0] ml);
        int n;
        if (req == REQ_READ) begin
            if (!rdy) begin
                push_res(KIND_STAT, 8'd0, 1'b1);
                return;
            end
            n = shadow_len;
            if (ml != 8'd0 && n > int'(ml) - 1) n = int'(ml) - 1;
            shadow_len = 0;
            rdy = 1'b0;
            for (int i = 0; i < n; i++) push_res(KIND_LINE, shadow_store[i], 1'b0);
            push_res(KIND_STAT, n[7:0], 1'b1);
            return;
        end
        echo_bytes.delete();
        if (raw_en) begin
            store_byte(b, 1'b0);
            rdy = 1'b1;
        end else begin
            cook_byte(b);
        end
        if (echo_bytes.size() == 0) begin
            push_res(KIND_STAT, 8'd0, 1'b1);
        end else begin
            foreach (echo_bytes[i])
                push_res(KIND_ECHO, echo_bytes[i], i == echo_bytes.size() - 1);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            raw_en     = 1'b0;
            echo_en    = 1'b1;
            erase_ch   = RST_ERASE;
            kill_ch    = RST_KILL;
            intr_ch    = RST_INTR;
            eof_ch     = RST_EOF;
            eol_ch     = RST_EOL;
            shadow_len = 0;
            rdy        = 1'b0;
            esc_st     = ESC_GROUND;
            line_cnt   = '0;
            csi_cnt    = '0;
            errs       = 0;
            checked    = 0;
            tty_out_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    REG_RAW_MODE:   raw_en   = i_cfg_data[0];
                    REG_ECHO_ON:    echo_en  = i_cfg_data[0];
                    REG_ERASE_CHAR: erase_ch = i_cfg_data;
                    REG_KILL_CHAR:  kill_ch  = i_cfg_data;
                    REG_INTR_CHAR:  intr_ch  = i_cfg_data;
                    REG_EOF_CHAR:   eof_ch   = i_cfg_data;
                    REG_EOL_CHAR:   eol_ch   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) compute_tty_response(i_req_type, i_rx_byte, i_max_len);
            if (i_out_valid && i_out_ready) begin
                got = {i_kind, i_data, i_last, i_line_ready, i_lines_count, i_escape_count};
                if (tty_out_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected output: kind=%0d data=%02h last=%0b", i_kind,
                                 i_data, i_last);
                end else begin
                    want = tty_out_q.pop_front();
                    checked++;
                    if (got !== want) begin
                        errs++;
                        if (errs <= 10)
                            $display({"mismatch #%0d: want kind=%0d data=%02h last=%0b rdy=%0b ",
                                      "lines=%0d csi=%0d / got kind=%0d data=%02h last=%0b ",
                                      "rdy=%0b lines=%0d csi=%0d"}, checked,
                                     want.kind, want.data, want.last, want.line_rdy, want.lines,
                                     want.csis, got.kind, got.data, got.last, got.line_rdy,
                                     got.lines, got.csis);
                    end
                end
            end
        end
        o_fail_count <= errs;
        o_pending    <= tty_out_q.size();
        o_checked    <= checked;
        o_csi_total  <= csi_cnt;
    end

endmodule

/* verif/tb_terminal_line_discipline.sv */
// Stimulus and verdict for terminal_line_discipline; all prediction and
// comparison lives in tld_line_checker.
module tb_terminal_line_discipline;

    import tld_pkg::*;

    localparam int         DRAIN_GAP   = 8;    // output register plus sequencer slack
    localparam int         HOLD_CYCLES = 300;  // long receiver back-pressure
    localparam logic [2:0] REG_BEYOND  = 3'd7; // unmapped register index

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_req_type;
    logic [7:0]  i_rx_byte;
    logic [7:0]  i_max_len;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [7:0]  o_data;
    logic        o_last;
    logic        o_line_ready;
    logic [31:0] o_lines_count;
    logic [31:0] o_escape_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_addr;
    logic [7:0]  i_cfg_data;

    int          fail_cnt, pending, checked;
    logic [31:0] csi_total;

    // stimulus-side copy of the control characters, so random lines can aim at them
    logic [7:0] sh_erase, sh_kill, sh_intr, sh_eof, sh_eol;

    // idling knobs, percent of cycles
    int idle_pct, stall_pct;
    // long hold request: set by the stimulus, consumed once by the receiver
    logic hold_start, hold_used;
    int   hold_left;

    int n_items, n_reads, n_cfg;

    terminal_line_discipline i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_rx_byte      (i_rx_byte),
        .i_max_len      (i_max_len),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_data         (o_data),
        .o_last         (o_last),
        .o_line_ready   (o_line_ready),
        .o_lines_count  (o_lines_count),
        .o_escape_count (o_escape_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    tld_line_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_rx_byte      (i_rx_byte),
        .i_max_len      (i_max_len),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_kind         (o_kind),
        .i_data         (o_data),
        .i_last         (o_last),
        .i_line_ready   (o_line_ready),
        .i_lines_count  (o_lines_count),
        .i_escape_count (o_escape_count),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_cnt),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_csi_total    (csi_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: ready changes at the falling edge only. A long hold, once
    // requested, is counted down here while the sender keeps offering items.
    initial begin
        i_out_ready = 1'b0;
        hold_used   = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_start && !hold_used) begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // One input transfer. Random idle cycles go in front; valid then stays
    // high with a fixed payload until the transfer happens.
    task automatic send(input logic req, input logic [7:0] b, input logic [7:0] ml);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_req_type = req;
        i_rx_byte  = b;
        i_max_len  = ml;
        do @(posedge i_clk); while (!o_in_ready);
        n_items++;
        if (req == REQ_READ) n_reads++;
    endtask

    // max_len of a byte transfer is don't-care, so it is randomized for toggle
    task automatic send_byte(input logic [7:0] b);
        send(REQ_BYTE, b, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_read(input logic [7:0] ml);
        send(REQ_READ, 8'($urandom_range(0, 255)), ml);
    endtask

    // Reader sizes: mostly near the line depth (0 means no limit), sometimes anything
    function automatic logic [7:0] rand_len();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 20));
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Sender pause: every predicted result must have left the block
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        n_cfg++;
    endtask

    // Writes every register, only once the block has gone idle
    task automatic apply_setting(input logic [7:0] raw, input logic [7:0] echo,
                                 input logic [7:0] erase, input logic [7:0] kill,
                                 input logic [7:0] intr, input logic [7:0] eof,
                                 input logic [7:0] eol);
        drain();
        cfg_write(REG_RAW_MODE, raw);
        cfg_write(REG_ECHO_ON, echo);
        cfg_write(REG_ERASE_CHAR, erase);
        cfg_write(REG_KILL_CHAR, kill);
        cfg_write(REG_INTR_CHAR, intr);
        cfg_write(REG_EOF_CHAR, eof);
        cfg_write(REG_EOL_CHAR, eol);
        sh_erase = erase;
        sh_kill  = kill;
        sh_intr  = intr;
        sh_eof   = eof;
        sh_eol   = eol;
    endtask

    // Mostly complete lines (edits and CSI inside, then end of line and a read),
    // the rest line kills, interrupts and EOFs, loose or broken escapes, noise and reads.
    task automatic random_burst(input int target);
        int first, len, pick;
        first = n_items;
        while (n_items - first < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // a few long lines run into the full store
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 8);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 19))
                        0: send_byte(sh_erase);
                        1: send_byte(CH_BS);
                        2: begin
                            send_byte(CH_ESC);
                            send_byte(CH_LBRACK);
                            send_byte(8'($urandom_range(CH_DIG_LO, CH_DIG_HI)));
                            send_byte(8'($urandom_range(CH_FIN_LO, CH_FIN_HI)));
                        end
                        default: send_byte(printable());
                    endcase
                end
                send_byte($urandom_range(0, 1) ? sh_eol : CH_CR);
                send_read(rand_len());
            end else if (pick < 65) begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++) send_byte(printable());
                case ($urandom_range(0, 3))
                    0: send_byte(sh_kill);
                    1: send_byte(sh_intr);
                    2: send_byte(sh_eof);  // line not empty: plain append
                    default: begin
                        send_byte(sh_kill);
                        send_byte(sh_eof); // empty line now: marks ready
                        send_read(rand_len());
                    end
                endcase
            end else if (pick < 80) begin
                send_byte(CH_ESC);
                case ($urandom_range(0, 3))
                    0: begin
                        send_byte(CH_LBRACK);
                        len = $urandom_range(0, 3);
                        for (int k = 0; k < len; k++)
                            send_byte($urandom_range(0, 1) ?
                                      8'($urandom_range(CH_DIG_LO, CH_DIG_HI)) : CH_SEMI);
                        // sometimes an aborting byte instead of a final
                        send_byte(($urandom_range(0, 3) == 0) ? rand_byte() :
                                  8'($urandom_range(CH_FIN_LO, CH_FIN_HI)));
                    end
                    1: begin
                        send_byte(CH_RBRACK);
                        len = $urandom_range(0, 4);
                        for (int k = 0; k < len; k++) send_byte(printable());
                        send_byte($urandom_range(0, 1) ? CH_BEL : CH_ESC);
                    end
                    2: send_byte(rand_byte());
                    default: send_byte(CH_ESC);
                endcase
            end else if (pick < 93) begin
                send_byte(rand_byte());
            end else begin
                send_read(rand_len());
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_req_type  = REQ_BYTE;
        i_rx_byte   = 8'd0;
        i_max_len   = 8'd0;
        i_cfg_valid = 1'b0;
        i_cfg_addr  = REG_RAW_MODE;
        i_cfg_data  = 8'd0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_start  = 1'b0;
        n_items     = 0;
        n_reads     = 0;
        n_cfg       = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Cooked, echo on, reset values written explicitly (echo via bit 0 of 0xFF)
        apply_setting(8'h00, 8'hFF, RST_ERASE, RST_KILL, RST_INTR, RST_EOF, RST_EOL);

        // Directed: edits, EOF, escapes, reads against each limit case
        send_read(8'h01);          // nothing ready: single status
        send_byte(8'h7F);          // erase on empty line falls through to append
        send_byte(RST_EOF);        // EOF on a non-empty line appends too
        send_byte(CH_BS);
        send_byte(8'h7F);          // now effective erase, line empty again
        send_byte(RST_EOF);        // EOF on empty line: ready, no echo
        send_read(8'h00);          // zero length wraps: no limit
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(RST_KILL);       // three rubouts
        send_byte(8'h61);
        send_byte(RST_INTR);       // ^C CR CR LF, line dropped
        send_byte(CH_ESC);
        send_byte(CH_ESC);         // ESC after ESC passes and is appended
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        send_byte(8'h31);
        send_byte(CH_SEMI);
        send_byte(8'h48);          // CSI completes
        send_byte(CH_ESC);
        send_byte(CH_RBRACK);
        send_byte(CH_BEL);         // OSC closed by BEL
        send_byte(CH_LF);          // end of line with LF expansion
        send_read(8'h02);          // limit cuts the line to one byte

        drain();
        random_burst(24);

        // Cooked, silent, control characters at the extremes; sender mostly idle.
        // Raw bit written as 0 via 0xFE to check the width mask.
        apply_setting(8'hFE, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h01, CH_SEMI);
        idle_pct  = 75;
        stall_pct = 0;
        random_burst(20);

        // Raw mode under heavy back-pressure, with one long hold that backs
        // the block up into its input while bytes keep coming
        apply_setting(8'h01, 8'h01, RST_ERASE, RST_KILL, RST_INTR, RST_EOF, CH_CR);
        idle_pct  = 0;
        stall_pct = 75;
        random_burst(8);
        hold_start = 1'b1;
        for (int k = 0; k < 18; k++) send_byte(printable());
        send_read(8'h00);
        random_burst(10);

        // Cooked, remapped: ESC as interrupt, NUL as kill and end of line
        apply_setting(8'h00, 8'h01, 8'hFF, 8'h00, CH_ESC, CH_CR, 8'h00);
        idle_pct  = 30;
        stall_pct = 30;
        random_burst(12);
        drain();
        random_burst(12);

        // Back to reset values; the unmapped index must change nothing
        apply_setting(8'h00, 8'h01, RST_ERASE, RST_KILL, RST_INTR, RST_EOF, RST_EOL);
        cfg_write(REG_BEYOND, 8'hFF);
        idle_pct  = 0;
        stall_pct = 0;
        random_burst(12);

        drain();
        $display("covered %0d items (%0d reads) across five register settings, %0d writes",
                 n_items, n_reads, n_cfg);
        $display("%0d results compared, %0d CSI sequences counted, one long output hold",
                 checked, csi_total);
        if (fail_cnt == 0 && pending == 0)
            $display("tb_terminal_line_discipline: clean");
        else
            $display("tb_terminal_line_discipline: errors");
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial begin
        #3000000;
        $display("tb_terminal_line_discipline: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/tld_pkg.sv
rtl/core/tld_esc_filter.sv
rtl/core/terminal_line_discipline.sv
verif/tld_line_checker.sv
verif/tb_terminal_line_discipline.sv
